### hw/rtl/pfdw_pkg.sv
// ----------------------------------------------------------------------------
// pfdw_pkg
// Shared types and codes for the page framebuffer with dirty window.
// ----------------------------------------------------------------------------
package pfdw_pkg;

    typedef enum logic [2:0] {
        OP_CLEAR     = 3'd0,
        OP_SET_PIXEL = 3'd1,
        OP_BLIT      = 3'd2,
        OP_FLUSH     = 3'd3,
        OP_READ      = 3'd4
    } pfdw_op_t;

    localparam logic [1:0] MODE_WHITE   = 2'd0;
    localparam logic [1:0] MODE_BLACK   = 2'd1;
    localparam logic [1:0] MODE_INVERSE = 2'd2;

    localparam logic REG_DISPLAY_WIDTH = 1'b0;
    localparam logic REG_PAGE_COUNT    = 1'b1;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_DISPATCH,
        ST_CLEAR,
        ST_RD,
        ST_MOD,
        ST_RD2,
        ST_MOD2,
        ST_FLUSH,
        ST_DRAIN,
        ST_RESP
    } pfdw_state_t;

    typedef struct packed {
        logic capture;
        logic sweep_rst;
        logic sweep_adv;
        logic init_wr;
        logic clr_wr;
        logic rd_main;
        logic rd_spill;
        logic wr_main;
        logic wr_spill;
        logic fl_rd;
        logic win_clr;
        logic read_load;
        logic resp_load;
    } pfdw_cmd_t;

    typedef struct packed {
        logic [2:0] op;
        logic       acc_ok;
        logic       spill_ok;
        logic       area_last;
        logic       init_last;
        logic       out_free;
    } pfdw_status_t;

endpackage

### hw/rtl/page_framebuffer_dirty_window.sv
// ----------------------------------------------------------------------------
// page_framebuffer_dirty_window
// Page-organised monochrome framebuffer with a dirty-window flush.
//
// Commands arrive as beats on the s_ channel (valid/ready); each command
// returns exactly one beat on the m_ channel. Configuration is a plain write
// port (cfg_wr_en, cfg_index, cfg_wr_data); the user must write it only
// while idle, the block does not enforce this. After reset both stores are
// zeroed by a pass over all MAX_COLUMNS * MAX_PAGES entries (1024 by
// default); s_ready stays low until it ends. One command is in flight at a
// time. Invalid or unknown commands go straight to the result beat; set
// pixel and read access one byte, blit one or two (spill into the next
// page adds a second read-modify-write on the single front store); clear
// and flush sweep W*P bytes (one byte compared per cycle), where W and P
// are the clamped width and page count. The next command can be taken in the
// cycle after the result loads; an unaccepted beat holds the finished one.
// ----------------------------------------------------------------------------
module page_framebuffer_dirty_window
    import pfdw_pkg::*;
#(
    parameter int MAX_COLUMNS = 128,
    parameter int MAX_PAGES   = 8
)
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_wr_en,
    input  logic              cfg_index,
    input  logic [7:0]        cfg_wr_data,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [2:0]        s_operation,
    input  logic signed [8:0] s_column,
    input  logic signed [8:0] s_row,
    input  logic [1:0]        s_color_mode,
    input  logic [7:0]        s_data_byte,
    output logic              m_valid,
    input  logic              m_ready,
    output logic              m_window_changed,
    output logic [6:0]        m_min_column,
    output logic [6:0]        m_max_column,
    output logic [2:0]        m_min_page,
    output logic [2:0]        m_max_page,
    output logic [7:0]        m_read_data
);

    pfdw_cmd_t    cmd;
    pfdw_status_t status;

    pfdw_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    pfdw_datapath #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .MAX_PAGES   (MAX_PAGES)
    ) u_datapath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_index        (cfg_index),
        .cfg_wr_data      (cfg_wr_data),
        .s_operation      (s_operation),
        .s_column         (s_column),
        .s_row            (s_row),
        .s_color_mode     (s_color_mode),
        .s_data_byte      (s_data_byte),
        .cmd              (cmd),
        .status           (status),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_window_changed (m_window_changed),
        .m_min_column     (m_min_column),
        .m_max_column     (m_max_column),
        .m_min_page       (m_min_page),
        .m_max_page       (m_max_page),
        .m_read_data      (m_read_data)
    );

endmodule

### hw/rtl/pfdw_ctrl.sv
// ----------------------------------------------------------------------------
// pfdw_ctrl
// Sequencer: init pass, dispatch, read-modify-write, sweeps and response.
// ----------------------------------------------------------------------------
module pfdw_ctrl
    import pfdw_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_valid,
    output logic         s_ready,
    input  pfdw_status_t status,
    output pfdw_cmd_t    cmd
);

    pfdw_state_t state_reg;
    pfdw_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_INIT;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_INIT: begin
                if (status.init_last) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (s_valid) state_next = ST_DISPATCH;
            end
            ST_DISPATCH: begin
                case (status.op)
                    OP_CLEAR: state_next = ST_CLEAR;
                    OP_FLUSH: state_next = ST_FLUSH;
                    OP_SET_PIXEL, OP_BLIT, OP_READ:
                        state_next = status.acc_ok ? ST_RD : ST_RESP;
                    default: state_next = ST_RESP;
                endcase
            end
            ST_CLEAR: begin
                if (status.area_last) state_next = ST_RESP;
            end
            ST_RD:  state_next = ST_MOD;
            ST_MOD: begin
                if (status.op == OP_BLIT && status.spill_ok) state_next = ST_RD2;
                else state_next = ST_RESP;
            end
            ST_RD2:  state_next = ST_MOD2;
            ST_MOD2: state_next = ST_RESP;
            ST_FLUSH: begin
                if (status.area_last) state_next = ST_DRAIN;
            end
            ST_DRAIN: state_next = ST_RESP;
            ST_RESP: begin
                if (status.out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_INIT;
        endcase
    end

    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        case (state_reg)
            ST_INIT: begin
                cmd.init_wr   = 1'b1;
                cmd.sweep_adv = 1'b1;
            end
            ST_IDLE: begin
                s_ready     = 1'b1;
                cmd.capture = s_valid;
            end
            ST_DISPATCH: begin
                cmd.sweep_rst = 1'b1;
                cmd.win_clr   = 1'b1;
            end
            ST_CLEAR: begin
                cmd.clr_wr    = 1'b1;
                cmd.sweep_adv = 1'b1;
            end
            ST_RD:  cmd.rd_main = 1'b1;
            ST_MOD: begin
                if (status.op == OP_READ) cmd.read_load = 1'b1;
                else cmd.wr_main = 1'b1;
            end
            ST_RD2:  cmd.rd_spill = 1'b1;
            ST_MOD2: cmd.wr_spill = 1'b1;
            ST_FLUSH: begin
                cmd.fl_rd     = 1'b1;
                cmd.sweep_adv = 1'b1;
            end
            ST_DRAIN: ;
            ST_RESP: cmd.resp_load = status.out_free;
            default: ;
        endcase
    end

endmodule

### hw/rtl/pfdw_datapath.sv
// ----------------------------------------------------------------------------
// pfdw_datapath
// Stores, address generation, sweep counters, window tracking, result beat.
// ----------------------------------------------------------------------------
module pfdw_datapath
    import pfdw_pkg::*;
#(
    parameter int MAX_COLUMNS = 128,
    parameter int MAX_PAGES   = 8
)
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic               cfg_index,
    input  logic [7:0]         cfg_wr_data,
    input  logic [2:0]         s_operation,
    input  logic signed [8:0]  s_column,
    input  logic signed [8:0]  s_row,
    input  logic [1:0]         s_color_mode,
    input  logic [7:0]         s_data_byte,
    input  pfdw_cmd_t          cmd,
    output pfdw_status_t       status,
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_window_changed,
    output logic [6:0]         m_min_column,
    output logic [6:0]         m_max_column,
    output logic [2:0]         m_min_page,
    output logic [2:0]         m_max_page,
    output logic [7:0]         m_read_data
);

    localparam int DEPTH = MAX_COLUMNS * MAX_PAGES;
    localparam int AW    = $clog2(DEPTH);
    localparam int WW    = $clog2(MAX_COLUMNS + 1);
    localparam int PW    = $clog2(MAX_PAGES + 1);
    localparam int XW    = $clog2(MAX_COLUMNS);
    localparam int YW    = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
    localparam int MW    = WW + 5;

    logic [7:0] display_width_reg;
    logic [3:0] page_count_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            display_width_reg <= 8'd128;
            page_count_reg    <= 4'd8;
        end else if (cfg_wr_en) begin
            if (cfg_index == REG_DISPLAY_WIDTH) display_width_reg <= cfg_wr_data;
            else page_count_reg <= cfg_wr_data[3:0];
        end
    end

    logic [WW-1:0] w_eff;
    logic [PW-1:0] p_eff;

    always_comb begin
        if (display_width_reg == 8'd0) w_eff = WW'(1);
        else if (32'(display_width_reg) > MAX_COLUMNS) w_eff = WW'(MAX_COLUMNS);
        else w_eff = WW'(display_width_reg);
        if (page_count_reg == 4'd0) p_eff = PW'(1);
        else if (32'(page_count_reg) > MAX_PAGES) p_eff = PW'(MAX_PAGES);
        else p_eff = PW'(page_count_reg);
    end

    logic [2:0]        op_reg;
    logic signed [8:0] col_reg;
    logic signed [8:0] row_reg;
    logic [1:0]        mode_reg;
    logic [7:0]        data_reg;

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            op_reg   <= s_operation;
            col_reg  <= s_column;
            row_reg  <= s_row;
            mode_reg <= s_color_mode;
            data_reg <= s_data_byte;
        end
    end

    logic [4:0]    page;
    logic [2:0]    off;
    logic          col_ok;
    logic          row_ok;
    logic [MW-1:0] prod;
    logic [AW-1:0] idx;
    logic [AW-1:0] idx_spill;

    assign page      = row_reg[7:3];
    assign off       = row_reg[2:0];
    assign col_ok    = !col_reg[8] && ({1'b0, col_reg[7:0]} < 9'(w_eff));
    assign row_ok    = !row_reg[8] && (6'(page) < 6'(p_eff));
    assign prod      = MW'(page) * MW'(w_eff);
    assign idx       = AW'(prod + MW'(col_reg[7:0]));
    assign idx_spill = idx + AW'(w_eff);

    logic [XW-1:0] x_reg;
    logic [YW-1:0] y_reg;
    logic [AW-1:0] sw_addr_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.sweep_rst) begin
            x_reg       <= '0;
            y_reg       <= '0;
            sw_addr_reg <= '0;
        end else if (cmd.sweep_adv) begin
            sw_addr_reg <= sw_addr_reg + AW'(1);
            if ((WW+1)'(x_reg) == (WW+1)'(w_eff) - (WW+1)'(1)) begin
                x_reg <= '0;
                y_reg <= y_reg + YW'(1);
            end else begin
                x_reg <= x_reg + XW'(1);
            end
        end
    end

    logic [7:0] front_mem [DEPTH];
    logic [7:0] shadow_mem [DEPTH];
    logic [7:0] front_q;
    logic [7:0] shadow_q;
    logic [AW-1:0] front_raddr;

    logic          fl_v_reg;
    logic [XW-1:0] fl_x_reg;
    logic [YW-1:0] fl_y_reg;
    logic [AW-1:0] fl_a_reg;

    always_comb begin
        if (cmd.rd_spill) front_raddr = idx_spill;
        else if (cmd.rd_main) front_raddr = idx;
        else front_raddr = sw_addr_reg;
    end

    logic [7:0] bits;
    logic [7:0] mod_val;

    always_comb begin
        if (cmd.wr_spill) bits = 8'(data_reg >> (4'd8 - 4'(off)));
        else if (op_reg == OP_BLIT) bits = 8'(data_reg << off);
        else bits = 8'(8'd1 << off);
        case (mode_reg)
            MODE_WHITE:   mod_val = front_q | bits;
            MODE_BLACK:   mod_val = front_q & ~bits;
            MODE_INVERSE: mod_val = front_q ^ bits;
            default:      mod_val = front_q;
        endcase
    end

    always_ff @(posedge aclk) begin
        front_q <= front_mem[front_raddr];
        if (cmd.init_wr || cmd.clr_wr) front_mem[sw_addr_reg] <= 8'd0;
        else if (cmd.wr_main) front_mem[idx] <= mod_val;
        else if (cmd.wr_spill) front_mem[idx_spill] <= mod_val;
    end

    always_ff @(posedge aclk) begin
        shadow_q <= shadow_mem[sw_addr_reg];
        if (cmd.init_wr) shadow_mem[sw_addr_reg] <= 8'd0;
        else if (fl_v_reg) shadow_mem[fl_a_reg] <= front_q;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) fl_v_reg <= 1'b0;
        else fl_v_reg <= cmd.fl_rd;
        fl_x_reg <= x_reg;
        fl_y_reg <= y_reg;
        fl_a_reg <= sw_addr_reg;
    end

    logic          changed_reg;
    logic [XW-1:0] minc_reg;
    logic [XW-1:0] maxc_reg;
    logic [YW-1:0] minp_reg;
    logic [YW-1:0] maxp_reg;

    always_ff @(posedge aclk) begin
        if (cmd.win_clr) begin
            changed_reg <= 1'b0;
            minc_reg    <= '0;
            maxc_reg    <= '0;
            minp_reg    <= '0;
            maxp_reg    <= '0;
        end else if (fl_v_reg && front_q != shadow_q) begin
            changed_reg <= 1'b1;
            if (!changed_reg) begin
                minc_reg <= fl_x_reg;
                maxc_reg <= fl_x_reg;
                minp_reg <= fl_y_reg;
                maxp_reg <= fl_y_reg;
            end else begin
                if (fl_x_reg < minc_reg) minc_reg <= fl_x_reg;
                if (fl_x_reg > maxc_reg) maxc_reg <= fl_x_reg;
                if (fl_y_reg > maxp_reg) maxp_reg <= fl_y_reg;
            end
        end
    end

    logic [7:0] read_reg;

    always_ff @(posedge aclk) begin
        if (cmd.capture) read_reg <= 8'd0;
        else if (cmd.read_load) read_reg <= front_q;
    end

    logic m_valid_reg;
    logic is_flush;

    assign is_flush = (op_reg == OP_FLUSH) && changed_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) m_valid_reg <= 1'b0;
        else if (cmd.resp_load) m_valid_reg <= 1'b1;
        else if (m_ready) m_valid_reg <= 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (cmd.resp_load) begin
            m_window_changed <= is_flush;
            m_min_column     <= is_flush ? 7'(minc_reg) : 7'd0;
            m_max_column     <= is_flush ? 7'(maxc_reg) : 7'd0;
            m_min_page       <= is_flush ? 3'(minp_reg) : 3'd0;
            m_max_page       <= is_flush ? 3'(maxp_reg) : 3'd0;
            m_read_data      <= (op_reg == OP_READ) ? read_reg : 8'd0;
        end
    end

    assign m_valid = m_valid_reg;

    assign status.op        = op_reg;
    assign status.acc_ok    = col_ok && row_ok;
    assign status.spill_ok  = (off != 3'd0) && (6'(page) + 6'd1 < 6'(p_eff));
    assign status.area_last = ((WW+1)'(x_reg) == (WW+1)'(w_eff) - (WW+1)'(1))
                           && ((PW+1)'(y_reg) == (PW+1)'(p_eff) - (PW+1)'(1));
    assign status.init_last = (32'(sw_addr_reg) == DEPTH - 1);
    assign status.out_free  = !m_valid_reg || m_ready;

endmodule
